// ===== hw/rtl/bmed_pkg.sv =====
// ----------------------------------------------------------------------------
// bmed_pkg
// shared types, constants and helpers of the binary morphological edge core
// ----------------------------------------------------------------------------
package bmed_pkg;

  localparam int unsigned MAX_COLS_DEF = 2048;
  localparam int unsigned MAX_ROWS_DEF = 2048;

  localparam int unsigned CFG_DW = 12;
  localparam int unsigned CFG_IW = 1;

  localparam logic [CFG_DW-1:0] LINE_LENGTH_RST = 12'd640;
  localparam logic [CFG_DW-1:0] FRAME_ROWS_RST  = 12'd480;

  localparam int unsigned LUMA_W = 15;
  localparam logic [LUMA_W-1:0] LUMA_R    = 15'd30;
  localparam logic [LUMA_W-1:0] LUMA_G    = 15'd59;
  localparam logic [LUMA_W-1:0] LUMA_B    = 15'd11;
  localparam logic [LUMA_W-1:0] LUMA_THRS = 15'd12750;

  typedef enum logic [CFG_IW-1:0] {
    REG_LINE_LENGTH = 1'b0,
    REG_FRAME_ROWS  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic pixel_out;
    logic end_of_row;
    logic end_of_frame;
  } out_item_t;

  typedef struct packed {
    logic bit_in;
    logic ready;
    logic first_col;
    logic last_col;
    logic first_row;
    logic last_row;
  } feed_ctl_t;

  function automatic int unsigned eff_dim(logic [CFG_DW-1:0] v, int unsigned maxv);
    int unsigned r;
    r = int'(v);
    if (r == 0) r = 1;
    if (r > maxv) r = maxv;
    return r;
  endfunction

endpackage

// ===== hw/rtl/bmed_front.sv =====
// ----------------------------------------------------------------------------
// bmed_front
// request intake, binarization, raster counters and line store read issue
// ----------------------------------------------------------------------------
module bmed_front #(
  parameter int unsigned MAX_COLS = bmed_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = bmed_pkg::MAX_ROWS_DEF,
  localparam int unsigned AW = $clog2(MAX_COLS),
  localparam int unsigned CW = $clog2(MAX_COLS + 1),
  localparam int unsigned HW = $clog2(MAX_ROWS + 1),
  localparam int unsigned RW = $clog2(MAX_ROWS + 2)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  bmed_pkg::in_item_t        in_item_i,
  input  logic                      cfg_we_i,
  input  logic [bmed_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [bmed_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                      take_i,
  input  logic                      busy_i,
  output logic                      ev_valid_o,
  output logic [AW-1:0]             ev_col_o,
  output bmed_pkg::feed_ctl_t       ev_ctl_o
);

  logic [CW-1:0] w_q, w_d;
  logic [HW-1:0] h_q, h_d;
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic          pend2_q, pend2_d;

  logic                        accept;
  logic                        frame_done;
  logic                        feed;
  logic                        fbit;
  logic                        restart;
  logic                        flush_feed;
  logic                        ready;
  logic                        eor;
  logic                        eof;
  logic [CW-1:0]               f_col, f_oc;
  logic [RW-1:0]               f_row, f_or;
  logic [bmed_pkg::LUMA_W-1:0] luma;

  assign in_stall_o = busy_i || pend2_q || !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign frame_done = in_row_q >= RW'(h_q);

  assign luma = bmed_pkg::LUMA_R * bmed_pkg::LUMA_W'(in_item_i.red)
              + bmed_pkg::LUMA_G * bmed_pkg::LUMA_W'(in_item_i.green)
              + bmed_pkg::LUMA_B * bmed_pkg::LUMA_W'(in_item_i.blue);

  always_comb begin
    feed       = 1'b0;
    fbit       = 1'b1;
    restart    = 1'b0;
    flush_feed = 1'b0;
    if (pend2_q && take_i) begin
      feed = 1'b1;
    end else if (accept) begin
      if (in_item_i.mode == bmed_pkg::MODE_PIXEL) begin
        feed    = 1'b1;
        fbit    = luma >= bmed_pkg::LUMA_THRS;
        restart = frame_done;
      end else if (frame_done) begin
        feed       = 1'b1;
        flush_feed = 1'b1;
      end
    end
  end

  always_comb begin
    f_col = restart ? '0 : in_col_q;
    f_row = restart ? '0 : in_row_q;
    f_oc  = restart ? '0 : out_col_q;
    f_or  = restart ? '0 : out_row_q;
    ready = (f_col != '0) ? (f_row >= RW'(1)) : (f_row >= RW'(2));
    eor   = f_oc == (w_q - CW'(1));
    eof   = eor && (f_or == (RW'(h_q) - RW'(1)));
  end

  always_comb begin
    w_d       = w_q;
    h_d       = h_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pend2_d   = pend2_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bmed_pkg::REG_LINE_LENGTH: w_d = CW'(bmed_pkg::eff_dim(cfg_data_i, MAX_COLS));
        bmed_pkg::REG_FRAME_ROWS:  h_d = HW'(bmed_pkg::eff_dim(cfg_data_i, MAX_ROWS));
        default: ;
      endcase
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      pend2_d   = 1'b0;
    end else if (feed) begin
      if (f_col == (w_q - CW'(1))) begin
        in_col_d = '0;
        in_row_d = f_row + RW'(1);
      end else begin
        in_col_d = f_col + CW'(1);
        in_row_d = f_row;
      end
      out_col_d = f_oc;
      out_row_d = f_or;
      if (ready) begin
        if (eor) begin
          out_col_d = '0;
          out_row_d = f_or + RW'(1);
        end else begin
          out_col_d = f_oc + CW'(1);
        end
        if (eof) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end
      end
      pend2_d = flush_feed && !ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= CW'(bmed_pkg::eff_dim(bmed_pkg::LINE_LENGTH_RST, MAX_COLS));
      h_q       <= HW'(bmed_pkg::eff_dim(bmed_pkg::FRAME_ROWS_RST, MAX_ROWS));
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend2_q   <= 1'b0;
    end else begin
      w_q       <= w_d;
      h_q       <= h_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pend2_q   <= pend2_d;
    end
  end

  assign ev_valid_o         = feed && !cfg_we_i;
  assign ev_col_o           = f_col[AW-1:0];
  assign ev_ctl_o.bit_in    = fbit;
  assign ev_ctl_o.ready     = ready;
  assign ev_ctl_o.first_col = f_oc == '0;
  assign ev_ctl_o.last_col  = eor;
  assign ev_ctl_o.first_row = f_or == '0;
  assign ev_ctl_o.last_row  = f_or == (RW'(h_q) - RW'(1));

endmodule

// ===== hw/rtl/bmed_window.sv =====
// ----------------------------------------------------------------------------
// bmed_window
// binary line store, read-modify-write with forwarding, 3x3 window and edge test
// ----------------------------------------------------------------------------
module bmed_window #(
  parameter int unsigned MAX_COLS = bmed_pkg::MAX_COLS_DEF,
  localparam int unsigned AW = $clog2(MAX_COLS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ev_valid_i,
  input  logic [AW-1:0]        ev_col_i,
  input  bmed_pkg::feed_ctl_t  ev_ctl_i,
  input  logic                 out_free_i,
  output logic                 take_o,
  output logic                 busy_o,
  output logic                 res_valid_o,
  output bmed_pkg::out_item_t  res_item_o
);

  logic [1:0] mem [MAX_COLS];

  logic                clr_busy_q;
  logic [AW-1:0]       clr_addr_q;
  logic [1:0]          rdata_q;
  logic [1:0]          fwd_data_q;
  logic                s1_valid_q;
  logic [AW-1:0]       s1_col_q;
  bmed_pkg::feed_ctl_t s1_ctl_q;
  logic                s1_fwd_q;
  logic [8:0]          win_q;

  logic       s1_done;
  logic       take;
  logic [1:0] s;
  logic [1:0] wdata;
  logic [8:0] win_d;
  logic       edge_hit;

  assign s1_done = s1_valid_q && (!s1_ctl_q.ready || out_free_i);
  assign take    = !s1_valid_q || s1_done;
  assign s       = s1_fwd_q ? fwd_data_q : rdata_q;
  assign wdata   = {s[0], s1_ctl_q.bit_in};
  assign win_d   = {s1_ctl_q.bit_in, s[0], s[1], win_q[8:3]};

  always_comb begin
    edge_hit = 1'b0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(k == 1 && j == 1) && !(k == 0 && s1_ctl_q.first_col)
            && !(k == 2 && s1_ctl_q.last_col) && !(j == 0 && s1_ctl_q.first_row)
            && !(j == 2 && s1_ctl_q.last_row) && !win_d[k*3+j]) begin
          edge_hit = 1'b1;
        end
      end
    end
    edge_hit = edge_hit && win_d[4];
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= 2'b11;
    end else if (s1_done) begin
      mem[s1_col_q] <= wdata;
    end
    if (ev_valid_i) begin
      rdata_q <= mem[ev_col_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(MAX_COLS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
      win_q      <= '1;
    end else begin
      if (take) begin
        s1_valid_q <= ev_valid_i;
        if (ev_valid_i) begin
          s1_fwd_q <= s1_done && (s1_col_q == ev_col_i);
        end
      end
      if (s1_done) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && ev_valid_i) begin
      s1_col_q <= ev_col_i;
      s1_ctl_q <= ev_ctl_i;
    end
    if (s1_done) begin
      fwd_data_q <= wdata;
    end
  end

  assign take_o                  = take;
  assign busy_o                  = clr_busy_q;
  assign res_valid_o             = s1_valid_q && s1_ctl_q.ready;
  assign res_item_o.pixel_out    = !edge_hit;
  assign res_item_o.end_of_row   = s1_ctl_q.last_col;
  assign res_item_o.end_of_frame = s1_ctl_q.last_col && s1_ctl_q.last_row;

endmodule

// ===== hw/rtl/binary_morph_edge_detect_core.sv =====
// ----------------------------------------------------------------------------
// binary_morph_edge_detect_core
// registers: window stage s1, then the output register that drives out_valid_o
// throughput: one request per cycle while the output does not stall, set by the
// single line store read-modify-write; the first flush of a one-row frame
// feeds the window twice; reset: clears control state, then a line store clearing
// pass during which in_stall_o is high
// ----------------------------------------------------------------------------
module binary_morph_edge_detect_core #(
  parameter int unsigned MAX_COLS = bmed_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = bmed_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bmed_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bmed_pkg::out_item_t         out_item_o,
  input  logic                        cfg_we_i,
  input  logic [bmed_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [bmed_pkg::CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_COLS);

  logic                take;
  logic                busy;
  logic                ev_valid;
  logic [AW-1:0]       ev_col;
  bmed_pkg::feed_ctl_t ev_ctl;
  logic                res_valid;
  bmed_pkg::out_item_t res_item;
  logic                out_free;
  logic                out_valid_q;
  bmed_pkg::out_item_t out_item_q;

  bmed_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .take_i     (take),
    .busy_i     (busy),
    .ev_valid_o (ev_valid),
    .ev_col_o   (ev_col),
    .ev_ctl_o   (ev_ctl)
  );

  bmed_window #(
    .MAX_COLS (MAX_COLS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (ev_valid),
    .ev_col_i    (ev_col),
    .ev_ctl_i    (ev_ctl),
    .out_free_i  (out_free),
    .take_o      (take),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_item_o  (res_item)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
